[hdl/hsla_pkg.sv]
// hsla_pkg: shared constants and the pipeline stage type of the hsl adjust block
// no dependencies; used by hsla_div_step and hsl_saturation_luminance_adjust
package hsla_pkg;

    // fixed point constants, q1.16 apart from the hue turn, which counts 256 per sixth
    localparam int Q16_ONE        = 65536;
    localparam int SAT_GREY_LIMIT = 65;
    localparam int HUE_TURN       = 1536;

    // register reset values
    localparam logic [15:0] GAIN_RESET = 16'd4096;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_SATURATION_GAIN = 1'b0,
        REG_LUMINANCE_GAIN  = 1'b1
    } reg_index_t;

    // long division: quotient bits, bits per stage, stage count
    localparam int DIV_BITS   = 20;
    localparam int DIV_CHUNK  = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_CHUNK;

    // one pipeline stage; each stage uses the fields it needs
    typedef struct packed {
        logic [7:0]          r;
        logic [7:0]          g;
        logic [7:0]          b;
        logic                bypass;
        logic                grey;
        logic [7:0]          ch;
        logic [7:0]          den;
        logic [8:0]          sum;
        logic [16:0]         lum;
        logic [DIV_BITS-1:0] sn;
        logic [7:0]          srem;
        logic [DIV_BITS-1:0] sq;
        logic [DIV_BITS-1:0] hn;
        logic [7:0]          hrem;
        logic [DIV_BITS-1:0] hq;
        logic [16:0]         sat;
        logic [10:0]         hue;
        logic [16:0]         c;
        logic [8:0]          f;
        logic [16:0]         x;
        logic [7:0]          ro;
        logic [7:0]          go;
        logic [7:0]          bo;
    } pipe_t;

endpackage

[hdl/hsla_div_step.sv]
// hsla_div_step: DIV_CHUNK restoring division steps on an 8-bit divisor
// depends on hsla_pkg for the number of steps
module hsla_div_step (
    input  logic [7:0]                    rem_in,
    input  logic [hsla_pkg::DIV_CHUNK-1:0] num_bits,
    input  logic [7:0]                    den,
    output logic [7:0]                    rem_out,
    output logic [hsla_pkg::DIV_CHUNK-1:0] q_bits
);

    always_comb
    begin
        logic [8:0] t;
        logic [7:0] r;
        r = rem_in;
        q_bits = '0;
        for (int i = hsla_pkg::DIV_CHUNK - 1; i >= 0; i--)
        begin
            t = {r, num_bits[i]};
            if (t >= {1'b0, den})
            begin
                t = t - {1'b0, den};
                q_bits[i] = 1'b1;
            end
            r = t[7:0];
        end
        rem_out = r;
    end

endmodule

[hdl/hsl_saturation_luminance_adjust.sv]
// hsl_saturation_luminance_adjust: top level, rgb to hsl, gains, hsl back to rgb
// depends on hsla_pkg and hsla_div_step
//
// usage
//   input channel in_valid/in_ready carries one 8-bit rgb pixel per transfer,
//   output channel out_valid/out_ready returns one adjusted pixel per transfer,
//   in the same order
//   gains are written on cfg_write_en with cfg_index and cfg_data; the user
//   must write them only while the block is idle, the block does not enforce
//   it; both reset to 1.0 (4096 at 12 fractional bits)
//   throughput is one pixel per cycle while the output is not stalled; the
//   ten register stages are entry, five long division stages (four quotient
//   bits each, saturation and hue side by side), gain multiply, chroma
//   multiply, x multiply and the output register
//   each stage moves on when the stage after it is empty or moving, so a
//   stalled receiver fills bubbles first and then holds in_ready low;
//   nothing is lost or repeated
//   reset clears all stage valid bits and restores both gains
//   with both gains at exactly 1.0 the pixel passes through unchanged
module hsl_saturation_luminance_adjust #(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out
);

    localparam int NSTAGE = hsla_pkg::DIV_STAGES + 5;
    localparam int ST_GAIN = hsla_pkg::DIV_STAGES + 1;
    localparam int ST_C    = hsla_pkg::DIV_STAGES + 2;
    localparam int ST_X    = hsla_pkg::DIV_STAGES + 3;
    localparam int ST_OUT  = hsla_pkg::DIV_STAGES + 4;
    localparam logic [16:0] UNITY = 17'(1) << GAIN_FRAC_BITS;

    // configuration registers
    logic [15:0] sat_gain_reg;
    logic [15:0] lum_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_gain_reg <= hsla_pkg::GAIN_RESET;
            lum_gain_reg <= hsla_pkg::GAIN_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (hsla_pkg::reg_index_t'(cfg_index))
                hsla_pkg::REG_SATURATION_GAIN: sat_gain_reg <= cfg_data;
                hsla_pkg::REG_LUMINANCE_GAIN:  lum_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // gain multiply with round half up, clamped at 1.0
    function automatic logic [16:0] apply_gain(input logic [16:0] v, input logic [15:0] gain);
        logic [33:0] p;
        logic [33:0] q;
        p = 34'(v) * 34'(gain) + (34'(1) << (GAIN_FRAC_BITS - 1));
        q = p >> GAIN_FRAC_BITS;
        if (q > 34'(hsla_pkg::Q16_ONE))
            return 17'(hsla_pkg::Q16_ONE);
        return q[16:0];
    endfunction

    // doubled q1.16 component to a rounded, clamped byte
    function automatic logic [7:0] to_byte(input logic signed [20:0] v2);
        logic signed [29:0] v;
        logic [29:0] o;
        v = (30'(v2) <<< 8) - 30'(v2);
        o = ($unsigned(v) + 30'd65536) >> 17;
        if (v2 <= 21'sd0)
            return 8'd0;
        if (o > 30'd255)
            return 8'hFF;
        return o[7:0];
    endfunction

    // pipeline storage and flow control
    hsla_pkg::pipe_t st_reg  [NSTAGE];
    hsla_pkg::pipe_t st_next [NSTAGE];
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] adv;

    always_comb
    begin
        adv[NSTAGE-1] = !v_reg[NSTAGE-1] || out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NSTAGE; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTAGE; k++)
            if (adv[k])
                st_reg[k] <= st_next[k];
    end

    // entry: max, min, chroma, saturation divisor and hue numerator
    always_comb
    begin
        hsla_pkg::pipe_t n;
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [10:0] ch11;
        logic [10:0] num;
        n = '0;
        mx = (red_in > green_in) ? red_in : green_in;
        mx = (mx > blue_in) ? mx : blue_in;
        mn = (red_in < green_in) ? red_in : green_in;
        mn = (mn < blue_in) ? mn : blue_in;
        n.r = red_in;
        n.g = green_in;
        n.b = blue_in;
        n.bypass = ({1'b0, sat_gain_reg} == UNITY) && ({1'b0, lum_gain_reg} == UNITY);
        n.ch = mx - mn;
        n.grey = (n.ch == 8'd0);
        n.sum = {1'b0, mx} + {1'b0, mn};
        n.den = (n.sum <= 9'd255) ? n.sum[7:0] : 8'(9'd510 - n.sum);
        ch11 = {3'b0, n.ch};
        // hue numerator in sixths, red checked first, then green
        if (mx == red_in)
            num = (green_in >= blue_in) ? {3'b0, 8'(green_in - blue_in)}
                                        : 11'(ch11 * 11'd6 - {3'b0, 8'(blue_in - green_in)});
        else if (mx == green_in)
            num = 11'(ch11 * 11'd2 + {3'b0, blue_in} - {3'b0, red_in});
        else
            num = 11'(ch11 * 11'd4 + {3'b0, red_in} - {3'b0, green_in});
        // saturation dividend ch*2^16 + den/2, top bits seed the remainder
        n.srem = {4'b0, n.ch[7:4]};
        n.sn = {n.ch[3:0], 9'b0, n.den[7:1]};
        // hue dividend num*256 + ch/2
        n.hrem = 8'd0;
        n.hn = {1'b0, num, 1'b0, n.ch[7:1]};
        st_next[0] = n;
    end

    // long division stages, luminance via reciprocal in the first
    for (genvar k = 1; k <= hsla_pkg::DIV_STAGES; k++)
    begin : g_div
        localparam int TOP = hsla_pkg::DIV_BITS - 1 - hsla_pkg::DIV_CHUNK * (k - 1);
        logic [7:0] srem_o;
        logic [7:0] hrem_o;
        logic [hsla_pkg::DIV_CHUNK-1:0] sq_o;
        logic [hsla_pkg::DIV_CHUNK-1:0] hq_o;
        hsla_pkg::pipe_t nxt;

        hsla_div_step u_sat_div (
            .rem_in   (st_reg[k-1].srem),
            .num_bits (st_reg[k-1].sn[TOP -: hsla_pkg::DIV_CHUNK]),
            .den      (st_reg[k-1].den),
            .rem_out  (srem_o),
            .q_bits   (sq_o)
        );

        hsla_div_step u_hue_div (
            .rem_in   (st_reg[k-1].hrem),
            .num_bits (st_reg[k-1].hn[TOP -: hsla_pkg::DIV_CHUNK]),
            .den      (st_reg[k-1].ch),
            .rem_out  (hrem_o),
            .q_bits   (hq_o)
        );

        always_comb
        begin
            logic [15:0] ly;
            logic [31:0] lp;
            nxt = st_reg[k-1];
            nxt.srem = srem_o;
            nxt.hrem = hrem_o;
            nxt.sq = {st_reg[k-1].sq[hsla_pkg::DIV_BITS-hsla_pkg::DIV_CHUNK-1:0], sq_o};
            nxt.hq = {st_reg[k-1].hq[hsla_pkg::DIV_BITS-hsla_pkg::DIV_CHUNK-1:0], hq_o};
            // lum = 128*sum + (256*sum + 255)/510, that division equals
            // (128*sum + 127)/255, done exactly as *32897 >> 23
            ly = {st_reg[k-1].sum, 7'h7F};
            lp = 32'(ly) * 32'd32897;
            if (k == 1)
                nxt.lum = {1'b0, st_reg[k-1].sum, 7'b0} + 17'(lp[31:23]);
            if (k == 1)
            begin
                nxt.sq = '0;
                nxt.hq = {{(hsla_pkg::DIV_BITS-hsla_pkg::DIV_CHUNK){1'b0}}, hq_o};
                nxt.sq[hsla_pkg::DIV_CHUNK-1:0] = sq_o;
            end
        end

        assign st_next[k] = nxt;
    end

    // gains, hue wrap, grey pixel override
    always_comb
    begin
        hsla_pkg::pipe_t n;
        logic [10:0] h;
        logic [16:0] s;
        n = st_reg[ST_GAIN-1];
        h = st_reg[ST_GAIN-1].hq[10:0];
        if (h >= 11'(hsla_pkg::HUE_TURN))
            h = h - 11'(hsla_pkg::HUE_TURN);
        s = st_reg[ST_GAIN-1].sq[16:0];
        if (st_reg[ST_GAIN-1].grey)
        begin
            h = '0;
            s = '0;
        end
        n.hue = h;
        n.sat = apply_gain(s, sat_gain_reg);
        n.lum = apply_gain(st_reg[ST_GAIN-1].lum, lum_gain_reg);
        st_next[ST_GAIN] = n;
    end

    // chroma c and hue weight f
    always_comb
    begin
        hsla_pkg::pipe_t n;
        logic [17:0] twol;
        logic [16:0] dev;
        logic [16:0] span;
        logic [33:0] pc;
        logic [8:0]  hl;
        logic [8:0]  ad;
        n = st_reg[ST_C-1];
        twol = {st_reg[ST_C-1].lum, 1'b0};
        if (twol >= 18'(hsla_pkg::Q16_ONE))
            dev = 17'(twol - 18'(hsla_pkg::Q16_ONE));
        else
            dev = 17'(18'(hsla_pkg::Q16_ONE) - twol);
        span = 17'(18'(hsla_pkg::Q16_ONE) - {1'b0, dev});
        pc = 34'(span) * 34'(st_reg[ST_C-1].sat) + 34'd32768;
        n.c = pc[32:16];
        hl = st_reg[ST_C-1].hue[8:0];
        ad = (hl >= 9'd256) ? (hl - 9'd256) : (9'd256 - hl);
        n.f = 9'd256 - ad;
        st_next[ST_C] = n;
    end

    // second largest component x
    always_comb
    begin
        hsla_pkg::pipe_t n;
        logic [25:0] px;
        n = st_reg[ST_X-1];
        px = 26'(st_reg[ST_X-1].c) * 26'(st_reg[ST_X-1].f) + 26'd128;
        n.x = px[24:8];
        st_next[ST_X] = n;
    end

    // sector select and conversion to bytes
    always_comb
    begin
        hsla_pkg::pipe_t n;
        logic [17:0] twol;
        logic signed [20:0] m2;
        logic [16:0] c;
        logic [16:0] x;
        logic [16:0] cr;
        logic [16:0] cg;
        logic [16:0] cb;
        logic [10:0] h;
        logic [7:0]  grey_o;
        n = st_reg[ST_OUT-1];
        c = st_reg[ST_OUT-1].c;
        x = st_reg[ST_OUT-1].x;
        h = st_reg[ST_OUT-1].hue;
        twol = {st_reg[ST_OUT-1].lum, 1'b0};
        m2 = $signed({3'b0, twol}) - $signed({4'b0, c});
        if (h <= 11'd256)
        begin
            cr = c; cg = x; cb = '0;
        end
        else if (h <= 11'd512)
        begin
            cr = x; cg = c; cb = '0;
        end
        else if (h <= 11'd768)
        begin
            cr = '0; cg = c; cb = x;
        end
        else if (h <= 11'd1024)
        begin
            cr = '0; cg = x; cb = c;
        end
        else if (h <= 11'd1280)
        begin
            cr = x; cg = '0; cb = c;
        end
        else
        begin
            cr = c; cg = '0; cb = x;
        end
        grey_o = to_byte($signed({3'b0, twol}));
        if (st_reg[ST_OUT-1].bypass)
        begin
            n.ro = st_reg[ST_OUT-1].r;
            n.go = st_reg[ST_OUT-1].g;
            n.bo = st_reg[ST_OUT-1].b;
        end
        else if (st_reg[ST_OUT-1].sat <= 17'(hsla_pkg::SAT_GREY_LIMIT))
        begin
            // near-zero saturation: all components take the luminance
            n.ro = grey_o;
            n.go = grey_o;
            n.bo = grey_o;
        end
        else
        begin
            n.ro = to_byte($signed({3'b0, cr, 1'b0}) + m2);
            n.go = to_byte($signed({3'b0, cg, 1'b0}) + m2);
            n.bo = to_byte($signed({3'b0, cb, 1'b0}) + m2);
        end
        st_next[ST_OUT] = n;
    end

    assign out_valid = v_reg[ST_OUT];
    assign red_out   = st_reg[ST_OUT].ro;
    assign green_out = st_reg[ST_OUT].go;
    assign blue_out  = st_reg[ST_OUT].bo;

`ifndef NO_ASSERTIONS
    // saturation remainder stays below its divisor after the last division stage
    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_GAIN-1] && !st_reg[ST_GAIN-1].grey)
            |-> (st_reg[ST_GAIN-1].srem < st_reg[ST_GAIN-1].den))
        else $error("saturation remainder not below divisor");

    // quotients stay in range: saturation at most 1.0, hue at most one turn
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_GAIN-1] && !st_reg[ST_GAIN-1].grey)
            |-> (st_reg[ST_GAIN-1].sq <= 20'(hsla_pkg::Q16_ONE)
                 && st_reg[ST_GAIN-1].hq <= 20'(hsla_pkg::HUE_TURN)))
        else $error("division quotient out of range");

    // a full stage behind a stalled output holds its data
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_OUT] && !out_ready && v_reg[ST_X])
            |=> (v_reg[ST_X] && $stable(st_reg[ST_X].x)))
        else $error("stage lost data under stall");
`endif

endmodule

[tb/tb_hsl_saturation_luminance_adjust.sv]
// tb_hsl_saturation_luminance_adjust: self-checking bench for the hsl gain adjust block
// predicts each pixel in integer arithmetic and checks the output stream in order
// depends on hsla_pkg and hsl_saturation_luminance_adjust
`timescale 1ns / 1ps

module tb_hsl_saturation_luminance_adjust;

    localparam int GAIN_FRAC_BITS = 12;
    localparam int PIPE_LATENCY   = 10;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    hsla_pkg::reg_index_t cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;

    // bench copy of the gain registers
    logic [15:0] sat_gain_model;
    logic [15:0] lum_gain_model;

    pixel_t expected_pixels[$];
    int     mismatch_count;
    int     cycle_count;
    bit     sink_idles;     // random back-pressure on the output side
    bit     source_idles;   // random gaps on the input side
    int     sink_holdoff;   // cycles of forced output stall still to run

    hsl_saturation_luminance_adjust #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // round half up, clamp at one
    function automatic longint scale_by_gain(longint v, logic [15:0] gain);
        longint p;
        p = (v * longint'(gain) + (longint'(1) << (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
        return (p > hsla_pkg::Q16_ONE) ? longint'(hsla_pkg::Q16_ONE) : p;
    endfunction

    // doubled q1.16 component to an 8-bit channel
    function automatic logic [7:0] q17_to_channel(longint v2);
        longint o;
        if (v2 <= 0)
            return 8'd0;
        o = (v2 * 255 + 65536) >>> 17;
        return (o > 255) ? 8'd255 : o[7:0];
    endfunction

    function automatic pixel_t adjust_pixel(pixel_t p);
        pixel_t res;
        longint r, g, b, mx, mn, ch, sum, den, num;
        longint hue, sat, lum, twol, dev, c, x, hm, f, m2, cr, cg, cb;
        r = longint'(p.r);
        g = longint'(p.g);
        b = longint'(p.b);
        if (sat_gain_model == (1 << GAIN_FRAC_BITS) && lum_gain_model == (1 << GAIN_FRAC_BITS))
            return p;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        ch = mx - mn;
        sum = mx + mn;
        lum = ((sum << 16) + 255) / 510;
        hue = 0;
        sat = 0;
        if (ch != 0)
        begin
            den = (sum <= 255) ? sum : 510 - sum;
            sat = ((ch << 16) + den / 2) / den;
            if (mx == r)
                num = (g >= b) ? g - b : 6 * ch - (b - g);
            else if (mx == g)
                num = 2 * ch + b - r;
            else
                num = 4 * ch + r - g;
            hue = (num * 256 + ch / 2) / ch;
            if (hue >= hsla_pkg::HUE_TURN)
                hue -= hsla_pkg::HUE_TURN;
        end
        sat = scale_by_gain(sat, sat_gain_model);
        lum = scale_by_gain(lum, lum_gain_model);
        if (sat <= hsla_pkg::SAT_GREY_LIMIT)
        begin
            res.r = q17_to_channel(lum * 2);
            res.g = res.r;
            res.b = res.r;
            return res;
        end
        twol = lum * 2;
        dev = twol - hsla_pkg::Q16_ONE;
        if (dev < 0)
            dev = -dev;
        c = ((hsla_pkg::Q16_ONE - dev) * sat + 32768) / 65536;
        hm = (hue & 511) - 256;
        f = 256 - ((hm < 0) ? -hm : hm);
        x = (c * f + 128) / 256;
        // pick the hue sector
        if (hue <= 256)       begin cr = c; cg = x; cb = 0; end
        else if (hue <= 512)  begin cr = x; cg = c; cb = 0; end
        else if (hue <= 768)  begin cr = 0; cg = c; cb = x; end
        else if (hue <= 1024) begin cr = 0; cg = x; cb = c; end
        else if (hue <= 1280) begin cr = x; cg = 0; cb = c; end
        else                  begin cr = c; cg = 0; cb = x; end
        m2 = twol - c;
        res.r = q17_to_channel(2 * cr + m2);
        res.g = q17_to_channel(2 * cg + m2);
        res.b = q17_to_channel(2 * cb + m2);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // one input transfer; valid stays high until accepted and is dropped
    // only when the source idles or the stream pauses
    task automatic send_pixel(input pixel_t p);
        while (source_idles && ($urandom_range(99) < 13))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= p.r;
        green_in <= p.g;
        blue_in  <= p.b;
        expected_pixels.push_back(adjust_pixel(p));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_pixel();
        pixel_t p;
        p = 24'($urandom);
        // a share of near-grey pixels exercises the low-chroma path
        if ($urandom_range(9) == 0)
        begin
            p.g = 8'(p.r + $urandom_range(2) - 1);
            p.b = p.r;
        end
        send_pixel(p);
    endtask

    // register write, only while nothing is in flight
    task automatic write_gain(input hsla_pkg::reg_index_t idx, input logic [15:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        if (idx == hsla_pkg::REG_SATURATION_GAIN)
            sat_gain_model = value;
        else
            lum_gain_model = value;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2)
            @(negedge clk);
    endtask

    task automatic set_gains(input logic [15:0] sg, input logic [15:0] lg);
        wait_drained();
        write_gain(hsla_pkg::REG_SATURATION_GAIN, sg);
        write_gain(hsla_pkg::REG_LUMINANCE_GAIN, lg);
        cfg_write_en <= 1'b0;
    endtask

    // corners, primaries, greys and hue wrap points
    task automatic test_directed();
        pixel_t corners[$];
        corners = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
                    '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd0},
                    '{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd255}, '{8'd128, 8'd128, 8'd128},
                    '{8'd255, 8'd0, 8'd1}, '{8'd200, 8'd100, 8'd50}, '{8'd1, 8'd0, 8'd0},
                    '{8'd127, 8'd128, 8'd127}, '{8'd254, 8'd255, 8'd255}, '{8'd10, 8'd250, 8'd130},
                    '{8'd170, 8'd85, 8'd255}, '{8'd128, 8'd127, 8'd128}};
        foreach (corners[i])
            send_pixel(corners[i]);
    endtask

    // unity gains pass the pixel through
    task automatic test_unity_passthrough();
        set_gains(16'd4096, 16'd4096);
        repeat (150)
            send_random_pixel();
    endtask

    // zero and full-scale gains with the directed set under each matched pair, random pixels under the mixed ones
    task automatic test_gain_extremes();
        set_gains(16'd0, 16'd0);
        test_directed();
        set_gains(16'hFFFF, 16'hFFFF);
        test_directed();
        set_gains(16'd0, 16'hFFFF);
        repeat (60)
            send_random_pixel();
        set_gains(16'hFFFF, 16'd0);
        repeat (60)
            send_random_pixel();
    endtask

    // random gains in several phases, one with no idling on either side
    task automatic test_random_gains();
        for (int phase = 0; phase < 6; phase++)
        begin
            set_gains(16'($urandom_range(8192)), 16'($urandom_range(8192)));
            source_idles = (phase != 2);
            sink_idles   = (phase != 2);
            repeat (130)
                send_random_pixel();
        end
        source_idles = 1'b1;
        sink_idles   = 1'b1;
    endtask

    // receiver stalls for a long stretch while the sender keeps offering
    task automatic test_back_pressure();
        set_gains(16'd5000, 16'd3500);
        sink_holdoff = 60;
        repeat (200)
            send_random_pixel();
    endtask

    // output side: random stall, forced hold-off, and the checker
    always @(negedge clk)
    begin
        if (sink_holdoff > 0)
        begin
            sink_holdoff <= sink_holdoff - 1;
            out_ready    <= 1'b0;
        end
        else
            out_ready <= !(sink_idles && ($urandom_range(99) < 13));
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("unexpected output transfer at cycle %0d", cycle_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (red_out !== want.r)
                    report_mismatch("red", red_out, want.r);
                if (green_out !== want.g)
                    report_mismatch("green", green_out, want.g);
                if (blue_out !== want.b)
                    report_mismatch("blue", blue_out, want.b);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = hsla_pkg::REG_SATURATION_GAIN;
        cfg_data       = '0;
        in_valid       = 1'b0;
        red_in         = '0;
        green_in       = '0;
        blue_in        = '0;
        out_ready      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        sink_idles     = 1'b1;
        source_idles   = 1'b1;
        sink_holdoff   = 0;
        sat_gain_model = hsla_pkg::GAIN_RESET;
        lum_gain_model = hsla_pkg::GAIN_RESET;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset gains are unity
        test_directed();
        set_gains(16'd6144, 16'd3072);
        test_directed();
        test_unity_passthrough();
        test_gain_extremes();
        test_random_gains();
        test_back_pressure();

        wait_drained();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
hdl/hsla_pkg.sv
hdl/hsla_div_step.sv
hdl/hsl_saturation_luminance_adjust.sv
tb/tb_hsl_saturation_luminance_adjust.sv
